[hdl/mpbm_pkg.sv]
// Shared constants, codes and types for the multi-pattern byte masker.
package mpbm_pkg;

	localparam int NODE_COUNT      = 1024;
	localparam int ALPHABET        = 256;  // power of two: symbol is the low bits of the byte
	localparam int MAX_PATTERN_LEN = 16;
	localparam int OUT_LIMIT       = 20;
	localparam int OQ_SIZE         = 64;
	localparam int WALK_GUARD      = 64;

	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int SYM_W      = $clog2(ALPHABET);
	localparam int CHILD_AW   = NODE_W + SYM_W;
	localparam int CHILD_SIZE = NODE_COUNT * ALPHABET;
	localparam int LEN_W      = $clog2(MAX_PATTERN_LEN + 1);
	localparam int PEND_DEPTH = MAX_PATTERN_LEN + 1;
	localparam int PIDX_W     = $clog2(PEND_DEPTH);
	localparam int PCNT_W     = $clog2(PEND_DEPTH + 1);
	localparam int OQ_AW      = $clog2(OQ_SIZE);
	localparam int OQ_CW      = $clog2(OQ_SIZE + 1);
	localparam int DRN_W      = $clog2(OUT_LIMIT + 1);
	localparam int GW_W       = $clog2(WALK_GUARD);
	localparam int TG_W       = $clog2(WALK_GUARD + 1);

	localparam int BYTE_W     = 8;
	localparam int MLEN_W     = 4;
	localparam int FUNC_W     = 3;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 1;

	localparam logic [FUNC_W-1:0] F_PATTERN = 3'd0;
	localparam logic [FUNC_W-1:0] F_BUILD   = 3'd1;
	localparam logic [FUNC_W-1:0] F_TEXT    = 3'd2;
	localparam logic [FUNC_W-1:0] F_EOT     = 3'd3;
	localparam logic [FUNC_W-1:0] F_CLEAR   = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_LONG    = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOBUILD = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_MASK_CHAR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK_LEN  = 1'd1;

	localparam logic [BYTE_W-1:0] MASK_CHAR_RST = 8'd42;
	localparam logic [MLEN_W-1:0] MASK_LEN_RST  = 4'd3;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_PB_RD, S_PB_CHK,
		S_BD_INIT, S_BD_POP, S_BD_NODE, S_BD_CRD, S_BD_CCHK, S_BD_FGET,
		S_BD_WALK, S_BD_WCHK, S_BD_WR,
		S_TX_RD, S_TX_CHK, S_TX_FGET, S_TX_POST, S_TX_INFO,
		S_EMIT, S_MASK, S_DRAIN
	} state_t;

	typedef struct packed {
		logic             end_mark;
		logic [LEN_W-1:0] depth;
	} node_info_t;

	typedef struct packed {
		logic              is_mask;
		logic [BYTE_W-1:0] data;
	} oq_entry_t;

endpackage

[hdl/mpbm_ram.sv]
// Generic simple dual-port RAM with registered read.
module mpbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/multi_pattern_byte_masker_top.sv]
// Top level of the multi-pattern byte masker: trie tables, link builder and text scanner.
//
// Usage: present func, data_byte and pattern_end with start; a request is taken at the
// clock edge where start is high and busy is low. Load patterns one byte per request
// (func 0, pattern_end on the last byte), issue one build request (func 1), then stream
// text bytes (func 2) and close with end of text (func 3). Func 4 clears the tables.
// Every request gives one or more results, each shown for exactly one cycle with
// result_valid high; last marks the final one. The receiver cannot stall the block.
// Register writes (mask_char, mask_length) go over cfg_valid/cfg_ready, always ready.
// A pattern byte is looked up in the child table and then written. A text byte follows
// failure links as needed (at most 64 steps per byte), then queues its released bytes
// and, on a match, the mask bytes. Results then follow at one per cycle, at most 20 per
// request; leftovers go out ahead of the next request's bytes. Build walks every table
// entry of every reached node and its failure links.
// After reset, and on a clear request, the child table is swept to zero, one entry per
// cycle, with busy high. Config writes are taken during the sweep.
module multi_pattern_byte_masker_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [mpbm_pkg::FUNC_W-1:0]        func,
	input  logic [mpbm_pkg::BYTE_W-1:0]        data_byte,
	input  logic                               pattern_end,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mpbm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mpbm_pkg::BYTE_W-1:0]        cfg_data,
	output logic                               result_valid,
	output logic                               has_byte,
	output logic [mpbm_pkg::BYTE_W-1:0]        out_byte,
	output logic                               is_mask,
	output logic                               found_any,
	output logic [mpbm_pkg::STAT_W-1:0]        status,
	output logic                               last
);

	mpbm_pkg::state_t state_q, state_d;

	logic [mpbm_pkg::CHILD_AW-1:0] clr_addr_q;
	logic                          clr_resp_q;
	logic [mpbm_pkg::BYTE_W-1:0]   mask_char_q;
	logic [mpbm_pkg::MLEN_W-1:0]   mask_len_q;

	logic [mpbm_pkg::NODE_W:0]     nodes_used_q;
	logic [mpbm_pkg::NODE_W-1:0]   cursor_q;
	logic [mpbm_pkg::LEN_W-1:0]    len_q;
	logic [mpbm_pkg::STAT_W-1:0]   drop_q;
	logic [mpbm_pkg::NODE_W-1:0]   scan_q;
	logic                          built_q;
	logic                          any_q;

	logic [mpbm_pkg::SYM_W-1:0]    k_q;
	logic [mpbm_pkg::BYTE_W-1:0]   txt_q;
	logic                          pe_q;
	logic [mpbm_pkg::STAT_W-1:0]   st_q;
	logic                          found_q;

	logic [mpbm_pkg::NODE_W:0]     head_q, tail_q;
	logic [mpbm_pkg::NODE_W-1:0]   nd_q, ch_q, p_q, f_q;
	logic [mpbm_pkg::SYM_W-1:0]    c_q;
	logic [mpbm_pkg::GW_W-1:0]     gw_q;

	logic [mpbm_pkg::NODE_W-1:0]   node_q;
	logic [mpbm_pkg::TG_W-1:0]     tg_q;

	logic [mpbm_pkg::BYTE_W-1:0]   pend_q [mpbm_pkg::PEND_DEPTH];
	logic [mpbm_pkg::PCNT_W-1:0]   pcnt_q;
	logic [mpbm_pkg::PCNT_W-1:0]   emit_left_q;
	logic                          match_q;
	logic [mpbm_pkg::MLEN_W-1:0]   mcnt_q;

	logic [mpbm_pkg::OQ_AW-1:0]    oq_head_q;
	logic [mpbm_pkg::OQ_CW-1:0]    oq_cnt_q;
	logic [mpbm_pkg::DRN_W-1:0]    dr_cnt_q;

	logic rd_v_s1, hb_s1, last_s1;

	// memory ports
	logic                          child_we;
	logic [mpbm_pkg::CHILD_AW-1:0] child_waddr, child_raddr;
	logic [mpbm_pkg::NODE_W-1:0]   child_wdata, child_rdata;
	logic                          fail_we;
	logic [mpbm_pkg::NODE_W-1:0]   fail_waddr, fail_raddr, fail_wdata, fail_rdata;
	logic                          info_we;
	logic [mpbm_pkg::NODE_W-1:0]   info_waddr, info_raddr;
	mpbm_pkg::node_info_t          info_wdata, info_rdata;
	logic                          q_we;
	logic [mpbm_pkg::NODE_W-1:0]   q_waddr, q_raddr, q_wdata, q_rdata;
	logic                          oq_we;
	logic [mpbm_pkg::OQ_AW-1:0]    oq_waddr, oq_raddr;
	mpbm_pkg::oq_entry_t           oq_wdata, oq_rdata;

	// decode helpers
	logic                          pb_new, pb_full, pb_alloc;
	logic [mpbm_pkg::NODE_W-1:0]   pb_nxt;
	logic                          last_sym;
	logic                          wk_hit;
	logic                          ti_end;
	logic [mpbm_pkg::PCNT_W-1:0]   ti_depth, ti_len;
	logic                          oq_room;
	logic                          drain_last;

	assign pb_new   = (child_rdata == '0);
	assign pb_full  = pb_new && (nodes_used_q >= (mpbm_pkg::NODE_W+1)'(mpbm_pkg::NODE_COUNT));
	assign pb_alloc = pb_new && !pb_full;
	assign pb_nxt   = pb_new ? nodes_used_q[mpbm_pkg::NODE_W-1:0] : child_rdata;

	assign last_sym = (c_q == mpbm_pkg::SYM_W'(mpbm_pkg::ALPHABET - 1));
	assign wk_hit   = (child_rdata != '0) && (child_rdata != ch_q);

	// the root never carries an end mark and sits at depth zero
	assign ti_end   = (node_q != '0) && info_rdata.end_mark;
	assign ti_depth = (node_q != '0) ? mpbm_pkg::PCNT_W'(info_rdata.depth) : '0;
	assign ti_len   = (ti_depth > pcnt_q) ? pcnt_q : ti_depth;

	assign oq_room    = (oq_cnt_q < mpbm_pkg::OQ_CW'(mpbm_pkg::OQ_SIZE));
	assign drain_last = (oq_cnt_q <= mpbm_pkg::OQ_CW'(1))
		|| (dr_cnt_q == mpbm_pkg::DRN_W'(mpbm_pkg::OUT_LIMIT - 1));

	assign busy      = (state_q != mpbm_pkg::S_IDLE);
	assign cfg_ready = 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpbm_pkg::S_CLR: begin
				if (clr_addr_q == '1) begin
					state_d = clr_resp_q ? mpbm_pkg::S_DRAIN : mpbm_pkg::S_IDLE;
				end
			end
			mpbm_pkg::S_IDLE: begin
				if (start) begin
					unique case (func)
						mpbm_pkg::F_PATTERN: begin
							if (drop_q != mpbm_pkg::ST_OK ||
								len_q >= mpbm_pkg::LEN_W'(mpbm_pkg::MAX_PATTERN_LEN)) begin
								state_d = mpbm_pkg::S_DRAIN;
							end else begin
								state_d = mpbm_pkg::S_PB_RD;
							end
						end
						mpbm_pkg::F_BUILD: state_d = mpbm_pkg::S_BD_INIT;
						mpbm_pkg::F_TEXT:  state_d = built_q ? mpbm_pkg::S_TX_RD : mpbm_pkg::S_DRAIN;
						mpbm_pkg::F_EOT:   state_d = mpbm_pkg::S_EMIT;
						mpbm_pkg::F_CLEAR: state_d = mpbm_pkg::S_CLR;
						default:           state_d = mpbm_pkg::S_DRAIN;
					endcase
				end
			end
			mpbm_pkg::S_PB_RD:   state_d = mpbm_pkg::S_PB_CHK;
			mpbm_pkg::S_PB_CHK:  state_d = mpbm_pkg::S_DRAIN;
			mpbm_pkg::S_BD_INIT: state_d = mpbm_pkg::S_BD_POP;
			mpbm_pkg::S_BD_POP:  state_d = (head_q < tail_q) ? mpbm_pkg::S_BD_NODE : mpbm_pkg::S_DRAIN;
			mpbm_pkg::S_BD_NODE: state_d = mpbm_pkg::S_BD_CRD;
			mpbm_pkg::S_BD_CRD:  state_d = mpbm_pkg::S_BD_CCHK;
			mpbm_pkg::S_BD_CCHK: begin
				if (child_rdata == '0) begin
					state_d = last_sym ? mpbm_pkg::S_BD_POP : mpbm_pkg::S_BD_CRD;
				end else if (nd_q == '0) begin
					state_d = mpbm_pkg::S_BD_WR;
				end else begin
					state_d = mpbm_pkg::S_BD_FGET;
				end
			end
			mpbm_pkg::S_BD_FGET: state_d = mpbm_pkg::S_BD_WALK;
			mpbm_pkg::S_BD_WALK: state_d = mpbm_pkg::S_BD_WCHK;
			mpbm_pkg::S_BD_WCHK: begin
				if (wk_hit || p_q == '0 || gw_q == mpbm_pkg::GW_W'(mpbm_pkg::WALK_GUARD - 1)) begin
					state_d = mpbm_pkg::S_BD_WR;
				end else begin
					state_d = mpbm_pkg::S_BD_FGET;
				end
			end
			mpbm_pkg::S_BD_WR:   state_d = last_sym ? mpbm_pkg::S_BD_POP : mpbm_pkg::S_BD_CRD;
			mpbm_pkg::S_TX_RD:   state_d = mpbm_pkg::S_TX_CHK;
			mpbm_pkg::S_TX_CHK: begin
				if (node_q == '0 || child_rdata != '0) begin
					state_d = mpbm_pkg::S_TX_POST;
				end else if (tg_q == mpbm_pkg::TG_W'(mpbm_pkg::WALK_GUARD)) begin
					state_d = mpbm_pkg::S_TX_RD;
				end else begin
					state_d = mpbm_pkg::S_TX_FGET;
				end
			end
			mpbm_pkg::S_TX_FGET: state_d = mpbm_pkg::S_TX_RD;
			mpbm_pkg::S_TX_POST: state_d = mpbm_pkg::S_TX_INFO;
			mpbm_pkg::S_TX_INFO: state_d = mpbm_pkg::S_EMIT;
			mpbm_pkg::S_EMIT: begin
				if (emit_left_q == '0) begin
					state_d = match_q ? mpbm_pkg::S_MASK : mpbm_pkg::S_DRAIN;
				end
			end
			mpbm_pkg::S_MASK: begin
				if (mcnt_q == '0) begin
					state_d = mpbm_pkg::S_DRAIN;
				end
			end
			mpbm_pkg::S_DRAIN: begin
				if (drain_last) begin
					state_d = mpbm_pkg::S_IDLE;
				end
			end
			default: state_d = mpbm_pkg::S_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		child_we    = 1'b0;
		child_waddr = {cursor_q, k_q};
		child_wdata = pb_nxt;
		child_raddr = '0;
		fail_we     = 1'b0;
		fail_waddr  = pb_nxt;
		fail_wdata  = '0;
		fail_raddr  = '0;
		info_we     = 1'b0;
		info_waddr  = pb_nxt;
		info_wdata  = '{end_mark: pe_q, depth: len_q + 1'b1};
		info_raddr  = node_q;
		q_we        = 1'b0;
		q_waddr     = tail_q[mpbm_pkg::NODE_W-1:0];
		q_wdata     = ch_q;
		q_raddr     = head_q[mpbm_pkg::NODE_W-1:0];
		oq_we       = 1'b0;
		oq_waddr    = oq_head_q + oq_cnt_q[mpbm_pkg::OQ_AW-1:0];
		oq_wdata    = '{is_mask: 1'b0, data: pend_q[0]};
		oq_raddr    = oq_head_q;
		unique case (state_q)
			mpbm_pkg::S_CLR: begin
				child_we    = 1'b1;
				child_waddr = clr_addr_q;
				child_wdata = '0;
			end
			mpbm_pkg::S_PB_RD: child_raddr = {cursor_q, k_q};
			mpbm_pkg::S_PB_CHK: begin
				child_we = pb_alloc;
				fail_we  = pb_alloc;
				info_we  = !pb_full && (pb_new || pe_q);
			end
			mpbm_pkg::S_BD_INIT: begin
				q_we    = 1'b1;
				q_waddr = '0;
				q_wdata = '0;
			end
			mpbm_pkg::S_BD_CRD:  child_raddr = {nd_q, c_q};
			mpbm_pkg::S_BD_CCHK: fail_raddr = nd_q;
			mpbm_pkg::S_BD_WALK: child_raddr = {p_q, c_q};
			mpbm_pkg::S_BD_WCHK: fail_raddr = p_q;
			mpbm_pkg::S_BD_WR: begin
				fail_we    = 1'b1;
				fail_waddr = ch_q;
				fail_wdata = f_q;
				q_we       = (tail_q < (mpbm_pkg::NODE_W+1)'(mpbm_pkg::NODE_COUNT));
			end
			mpbm_pkg::S_TX_RD:  child_raddr = {node_q, k_q};
			mpbm_pkg::S_TX_CHK: fail_raddr = node_q;
			mpbm_pkg::S_EMIT:   oq_we = (emit_left_q != '0) && oq_room;
			mpbm_pkg::S_MASK: begin
				oq_we    = (mcnt_q != '0) && oq_room;
				oq_wdata = '{is_mask: 1'b1, data: mask_char_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mpbm_pkg::S_CLR;
			clr_addr_q   <= '0;
			clr_resp_q   <= 1'b0;
			mask_char_q  <= mpbm_pkg::MASK_CHAR_RST;
			mask_len_q   <= mpbm_pkg::MASK_LEN_RST;
			nodes_used_q <= (mpbm_pkg::NODE_W+1)'(1);
			cursor_q     <= '0;
			len_q        <= '0;
			drop_q       <= mpbm_pkg::ST_OK;
			scan_q       <= '0;
			built_q      <= 1'b0;
			any_q        <= 1'b0;
			k_q          <= '0;
			txt_q        <= '0;
			pe_q         <= 1'b0;
			st_q         <= mpbm_pkg::ST_OK;
			found_q      <= 1'b0;
			head_q       <= '0;
			tail_q       <= '0;
			nd_q         <= '0;
			ch_q         <= '0;
			p_q          <= '0;
			f_q          <= '0;
			c_q          <= '0;
			gw_q         <= '0;
			node_q       <= '0;
			tg_q         <= '0;
			for (int i = 0; i < mpbm_pkg::PEND_DEPTH; i++) begin
				pend_q[i] <= '0;
			end
			pcnt_q       <= '0;
			emit_left_q  <= '0;
			match_q      <= 1'b0;
			mcnt_q       <= '0;
			oq_head_q    <= '0;
			oq_cnt_q     <= '0;
			dr_cnt_q     <= '0;
			rd_v_s1      <= 1'b0;
			hb_s1        <= 1'b0;
			last_s1      <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				priority if (cfg_index == mpbm_pkg::CFG_MASK_CHAR) begin
					mask_char_q <= cfg_data;
				end else if (cfg_index == mpbm_pkg::CFG_MASK_LEN) begin
					mask_len_q <= cfg_data[mpbm_pkg::MLEN_W-1:0];
				end
			end

			unique case (state_q)
				mpbm_pkg::S_CLR: clr_addr_q <= clr_addr_q + 1'b1;
				mpbm_pkg::S_IDLE: begin
					if (start) begin
						k_q      <= data_byte[mpbm_pkg::SYM_W-1:0];
						txt_q    <= data_byte;
						pe_q     <= pattern_end;
						st_q     <= mpbm_pkg::ST_OK;
						found_q  <= 1'b0;
						dr_cnt_q <= '0;
						unique case (func)
							mpbm_pkg::F_PATTERN: begin
								if (drop_q != mpbm_pkg::ST_OK) begin
									st_q <= drop_q;
								end else if (len_q >= mpbm_pkg::LEN_W'(mpbm_pkg::MAX_PATTERN_LEN)) begin
									st_q   <= mpbm_pkg::ST_LONG;
									drop_q <= mpbm_pkg::ST_LONG;
								end
								// dropped pattern: its end mark still resets the insert path
								if ((drop_q != mpbm_pkg::ST_OK ||
									len_q >= mpbm_pkg::LEN_W'(mpbm_pkg::MAX_PATTERN_LEN)) && pattern_end) begin
									cursor_q <= '0;
									len_q    <= '0;
									drop_q   <= mpbm_pkg::ST_OK;
								end
							end
							mpbm_pkg::F_TEXT: begin
								if (!built_q) begin
									st_q <= mpbm_pkg::ST_NOBUILD;
								end
								node_q <= scan_q;
								tg_q   <= '0;
							end
							mpbm_pkg::F_EOT: begin
								emit_left_q <= pcnt_q;
								match_q     <= 1'b0;
								scan_q      <= '0;
								found_q     <= any_q;
								any_q       <= 1'b0;
							end
							mpbm_pkg::F_CLEAR: begin
								clr_resp_q   <= 1'b1;
								nodes_used_q <= (mpbm_pkg::NODE_W+1)'(1);
								cursor_q     <= '0;
								len_q        <= '0;
								drop_q       <= mpbm_pkg::ST_OK;
								scan_q       <= '0;
								pcnt_q       <= '0;
								built_q      <= 1'b0;
								any_q        <= 1'b0;
								oq_head_q    <= '0;
								oq_cnt_q     <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				mpbm_pkg::S_PB_CHK: begin
					if (pb_full) begin
						st_q   <= mpbm_pkg::ST_FULL;
						drop_q <= mpbm_pkg::ST_FULL;
					end else begin
						cursor_q <= pb_nxt;
						len_q    <= len_q + 1'b1;
					end
					if (pb_alloc) begin
						nodes_used_q <= nodes_used_q + 1'b1;
						built_q      <= 1'b0;
					end
					if (pe_q) begin
						cursor_q <= '0;
						len_q    <= '0;
						drop_q   <= mpbm_pkg::ST_OK;
					end
				end
				mpbm_pkg::S_BD_INIT: begin
					head_q <= '0;
					tail_q <= (mpbm_pkg::NODE_W+1)'(1);
				end
				mpbm_pkg::S_BD_POP: begin
					if (head_q < tail_q) begin
						head_q <= head_q + 1'b1;
					end else begin
						built_q <= 1'b1;
					end
				end
				mpbm_pkg::S_BD_NODE: begin
					nd_q <= q_rdata;
					c_q  <= '0;
				end
				mpbm_pkg::S_BD_CCHK: begin
					ch_q <= child_rdata;
					f_q  <= '0;
					gw_q <= '0;
					if (child_rdata == '0) begin
						c_q <= c_q + 1'b1;
					end
				end
				mpbm_pkg::S_BD_FGET: p_q <= fail_rdata;
				mpbm_pkg::S_BD_WCHK: begin
					if (wk_hit) begin
						f_q <= child_rdata;
					end
					gw_q <= gw_q + 1'b1;
				end
				mpbm_pkg::S_BD_WR: begin
					if (tail_q < (mpbm_pkg::NODE_W+1)'(mpbm_pkg::NODE_COUNT)) begin
						tail_q <= tail_q + 1'b1;
					end
					c_q <= c_q + 1'b1;
				end
				mpbm_pkg::S_TX_CHK: begin
					if (node_q == '0 || child_rdata != '0) begin
						node_q <= child_rdata;
					end else if (tg_q == mpbm_pkg::TG_W'(mpbm_pkg::WALK_GUARD)) begin
						// walk gave up: retry from the root
						node_q <= '0;
					end else begin
						tg_q <= tg_q + 1'b1;
					end
				end
				mpbm_pkg::S_TX_FGET: node_q <= fail_rdata;
				mpbm_pkg::S_TX_POST: begin
					if (pcnt_q <= mpbm_pkg::PCNT_W'(mpbm_pkg::MAX_PATTERN_LEN)) begin
						pend_q[pcnt_q[mpbm_pkg::PIDX_W-1:0]] <= txt_q;
						pcnt_q <= pcnt_q + 1'b1;
					end
				end
				mpbm_pkg::S_TX_INFO: begin
					if (ti_end) begin
						emit_left_q <= pcnt_q - ti_len;
						match_q     <= 1'b1;
						any_q       <= 1'b1;
						scan_q      <= '0;
					end else begin
						match_q     <= 1'b0;
						scan_q      <= node_q;
						emit_left_q <= (ti_depth < pcnt_q) ? (pcnt_q - ti_depth) : '0;
					end
				end
				mpbm_pkg::S_EMIT: begin
					if (emit_left_q != '0) begin
						for (int i = 0; i < mpbm_pkg::PEND_DEPTH - 1; i++) begin
							pend_q[i] <= pend_q[i+1];
						end
						pcnt_q      <= pcnt_q - 1'b1;
						emit_left_q <= emit_left_q - 1'b1;
						if (oq_room) begin
							oq_cnt_q <= oq_cnt_q + 1'b1;
						end
					end else if (match_q) begin
						pcnt_q <= '0;
						mcnt_q <= mask_len_q;
					end
				end
				mpbm_pkg::S_MASK: begin
					if (mcnt_q != '0) begin
						mcnt_q <= mcnt_q - 1'b1;
						if (oq_room) begin
							oq_cnt_q <= oq_cnt_q + 1'b1;
						end
					end
				end
				mpbm_pkg::S_DRAIN: begin
					rd_v_s1 <= 1'b1;
					hb_s1   <= (oq_cnt_q != '0);
					last_s1 <= drain_last;
					if (oq_cnt_q != '0) begin
						oq_head_q <= oq_head_q + 1'b1;
						oq_cnt_q  <= oq_cnt_q - 1'b1;
						dr_cnt_q  <= dr_cnt_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	mpbm_ram #(.WIDTH(mpbm_pkg::NODE_W), .DEPTH(mpbm_pkg::CHILD_SIZE)) u_child_ram (
		.clk  (clk),
		.we   (child_we),
		.waddr(child_waddr),
		.wdata(child_wdata),
		.raddr(child_raddr),
		.rdata(child_rdata)
	);

	mpbm_ram #(.WIDTH(mpbm_pkg::NODE_W), .DEPTH(mpbm_pkg::NODE_COUNT)) u_fail_ram (
		.clk  (clk),
		.we   (fail_we),
		.waddr(fail_waddr),
		.wdata(fail_wdata),
		.raddr(fail_raddr),
		.rdata(fail_rdata)
	);

	mpbm_ram #(.WIDTH($bits(mpbm_pkg::node_info_t)), .DEPTH(mpbm_pkg::NODE_COUNT)) u_info_ram (
		.clk  (clk),
		.we   (info_we),
		.waddr(info_waddr),
		.wdata(info_wdata),
		.raddr(info_raddr),
		.rdata(info_rdata)
	);

	mpbm_ram #(.WIDTH(mpbm_pkg::NODE_W), .DEPTH(mpbm_pkg::NODE_COUNT)) u_bfs_ram (
		.clk  (clk),
		.we   (q_we),
		.waddr(q_waddr),
		.wdata(q_wdata),
		.raddr(q_raddr),
		.rdata(q_rdata)
	);

	mpbm_ram #(.WIDTH($bits(mpbm_pkg::oq_entry_t)), .DEPTH(mpbm_pkg::OQ_SIZE)) u_oq_ram (
		.clk  (clk),
		.we   (oq_we),
		.waddr(oq_waddr),
		.wdata(oq_wdata),
		.raddr(oq_raddr),
		.rdata(oq_rdata)
	);

	assign result_valid = rd_v_s1;
	assign has_byte     = rd_v_s1 & hb_s1;
	assign out_byte     = has_byte ? oq_rdata.data : '0;
	assign is_mask      = has_byte & oq_rdata.is_mask;
	assign found_any    = rd_v_s1 & found_q;
	assign status       = rd_v_s1 ? st_q : mpbm_pkg::ST_OK;
	assign last         = rd_v_s1 & last_s1;

	a_empty_alone: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !has_byte |-> last)
		else $error("empty result is not the only result of its request");

	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= mpbm_pkg::OQ_CW'(mpbm_pkg::OQ_SIZE))
		else $error("output queue count beyond its size");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= mpbm_pkg::PCNT_W'(mpbm_pkg::PEND_DEPTH))
		else $error("pending byte count beyond its depth");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken without going busy");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !result_valid)
		else $error("result directly after the final result of a request");

endmodule

[tb/sv/multi_pattern_byte_masker_top_tb.sv]
// Self-checking testbench for the multi-pattern byte masker top level.
module multi_pattern_byte_masker_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [mpbm_pkg::FUNC_W-1:0] F_NOP5 = 3'd5;
	localparam logic [mpbm_pkg::FUNC_W-1:0] F_NOP7 = 3'd7;
	localparam int RANDOM_ITEMS = 420;
	localparam longint CYCLE_LIMIT = 6000000;

	typedef struct packed {
		logic                        has_byte;
		logic [mpbm_pkg::BYTE_W-1:0] out_byte;
		logic                        is_mask;
		logic                        found_any;
		logic [mpbm_pkg::STAT_W-1:0] status;
		logic                        last;
	} masked_out_t;

	typedef struct {
		logic [mpbm_pkg::FUNC_W-1:0] func;
		logic [mpbm_pkg::BYTE_W-1:0] data;
		logic                        pend;
		int                          want_status;  // -1: compare with the predictor only
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [mpbm_pkg::FUNC_W-1:0] func = '0;
	logic [mpbm_pkg::BYTE_W-1:0] data_byte = '0;
	logic pattern_end = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [mpbm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [mpbm_pkg::BYTE_W-1:0] cfg_data = '0;
	logic result_valid;
	logic has_byte;
	logic [mpbm_pkg::BYTE_W-1:0] out_byte;
	logic is_mask;
	logic found_any;
	logic [mpbm_pkg::STAT_W-1:0] status;
	logic last;

	multi_pattern_byte_masker_top uut (.*);

	always #1 clk = ~clk;

	// trie and scanner mirror
	int unsigned child_map[int unsigned];
	int unsigned fail_of[mpbm_pkg::NODE_COUNT];
	int unsigned end_len[mpbm_pkg::NODE_COUNT];
	int unsigned depth_of[mpbm_pkg::NODE_COUNT];
	int unsigned nodes_used, ins_node, ins_len, ins_fault, scan_at;
	logic [7:0] pend_q[$];
	logic [8:0] outq[$];  // {is_mask, byte}
	bit trie_built, replaced;
	logic [7:0] mask_char_r;
	logic [3:0] mask_len_r;

	masked_out_t expected_q[$];
	int mismatches = 0;
	int accepted = 0;
	bit no_gaps = 0;
	longint cycles = 0;

	function automatic int unsigned child_of(int unsigned node, int unsigned sym);
		int unsigned key;
		key = node * mpbm_pkg::ALPHABET + sym;
		return child_map.exists(key) ? child_map[key] : 0;
	endfunction

	function automatic void trie_clear();
		child_map.delete();
		for (int i = 0; i < mpbm_pkg::NODE_COUNT; i++) begin
			fail_of[i] = 0;
			end_len[i] = 0;
			depth_of[i] = 0;
		end
		nodes_used = 1;
		ins_node = 0;
		ins_len = 0;
		ins_fault = 0;
		scan_at = 0;
		pend_q.delete();
		outq.delete();
		trie_built = 0;
		replaced = 0;
	endfunction

	function automatic void queue_byte(logic [7:0] b, logic m);
		if (outq.size() < mpbm_pkg::OQ_SIZE)
			outq.push_back({m, b});
	endfunction

	function automatic void release_front(int unsigned n);
		if (n > pend_q.size())
			n = pend_q.size();
		repeat (n) queue_byte(pend_q.pop_front(), 1'b0);
	endfunction

	function automatic int unsigned insert_byte(int unsigned sym, logic pe);
		int unsigned st, nxt;
		st = 0;
		if (ins_fault != 0) begin
			st = ins_fault;
		end else if (ins_len >= mpbm_pkg::MAX_PATTERN_LEN) begin
			st = mpbm_pkg::ST_LONG;
			ins_fault = mpbm_pkg::ST_LONG;
		end else begin
			nxt = child_of(ins_node, sym);
			if (nxt == 0) begin
				if (nodes_used >= mpbm_pkg::NODE_COUNT) begin
					st = mpbm_pkg::ST_FULL;
					ins_fault = mpbm_pkg::ST_FULL;
				end else begin
					nxt = nodes_used++;
					child_map[ins_node * mpbm_pkg::ALPHABET + sym] = nxt;
					fail_of[nxt] = 0;
					end_len[nxt] = 0;
					depth_of[nxt] = ins_len + 1;
					trie_built = 0;
				end
			end
			if (ins_fault == 0) begin
				ins_node = nxt;
				ins_len++;
			end
		end
		if (pe) begin
			if (ins_fault == 0 && ins_node != 0)
				end_len[ins_node] = ins_len;
			ins_node = 0;
			ins_len = 0;
			ins_fault = 0;
		end
		return st;
	endfunction

	function automatic void link_failures();
		int unsigned bfs[$];
		int unsigned nd, ch, p, q, f, pushed;
		bfs.push_back(0);
		pushed = 1;
		fail_of[0] = 0;
		while (bfs.size() > 0) begin
			nd = bfs.pop_front();
			for (int c = 0; c < mpbm_pkg::ALPHABET; c++) begin
				ch = child_of(nd, c);
				if (ch != 0) begin
					f = 0;
					if (nd != 0) begin
						p = fail_of[nd];
						for (int g = 0; g < mpbm_pkg::WALK_GUARD; g++) begin
							q = child_of(p, c);
							if (q != 0 && q != ch) begin
								f = q;
								break;
							end
							if (p == 0)
								break;
							p = fail_of[p];
						end
					end
					fail_of[ch] = f;
					if (pushed < mpbm_pkg::NODE_COUNT) begin
						bfs.push_back(ch);
						pushed++;
					end
				end
			end
		end
		trie_built = 1;
	endfunction

	function automatic void scan_byte(logic [7:0] b);
		int unsigned node, nx, len;
		node = scan_at;
		for (int g = 0; g < mpbm_pkg::WALK_GUARD; g++) begin
			if (node == 0 || child_of(node, b) != 0)
				break;
			node = fail_of[node];
		end
		if (child_of(node, b) == 0 && node != 0)
			node = 0;
		nx = child_of(node, b);
		if (nx != 0)
			node = nx;
		if (pend_q.size() <= mpbm_pkg::MAX_PATTERN_LEN)
			pend_q.push_back(b);
		if (node != 0 && end_len[node] != 0) begin
			len = end_len[node];
			if (len > pend_q.size())
				len = pend_q.size();
			release_front(pend_q.size() - len);
			pend_q.delete();
			repeat (mask_len_r) queue_byte(mask_char_r, 1'b1);
			node = 0;
			replaced = 1;
		end else if (depth_of[node] < pend_q.size()) begin
			release_front(pend_q.size() - depth_of[node]);
		end
		scan_at = node;
	endfunction

	// apply one accepted request and queue the results it owes; returns its status
	function automatic int unsigned predict_masker(logic [mpbm_pkg::FUNC_W-1:0] f,
			logic [7:0] b, logic pe);
		int unsigned st, n;
		logic found;
		masked_out_t r;
		st = 0;
		found = 0;
		n = 0;
		case (f)
			mpbm_pkg::F_PATTERN: st = insert_byte(b, pe);
			mpbm_pkg::F_BUILD: link_failures();
			mpbm_pkg::F_TEXT: begin
				if (!trie_built)
					st = mpbm_pkg::ST_NOBUILD;
				else
					scan_byte(b);
			end
			mpbm_pkg::F_EOT: begin
				release_front(pend_q.size());
				scan_at = 0;
				found = replaced;
				replaced = 0;
			end
			mpbm_pkg::F_CLEAR: trie_clear();
			default: ;
		endcase
		while (outq.size() > 0 && n < mpbm_pkg::OUT_LIMIT) begin
			r.has_byte = 1'b1;
			{r.is_mask, r.out_byte} = outq.pop_front();
			r.found_any = found;
			r.status = st[1:0];
			r.last = (outq.size() == 0 || n + 1 == mpbm_pkg::OUT_LIMIT);
			expected_q.push_back(r);
			n++;
		end
		if (n == 0) begin
			r = '0;
			r.found_any = found;
			r.status = st[1:0];
			r.last = 1'b1;
			expected_q.push_back(r);
		end
		return st;
	endfunction

	// call at a rising edge; returns at the edge that takes the request
	task automatic send_request(logic [mpbm_pkg::FUNC_W-1:0] f, logic [7:0] b, logic pe,
			int want = -1);
		int unsigned st;
		if (!no_gaps && $urandom_range(0, 99) < 6) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		data_byte <= b;
		pattern_end <= pe;
		do @(posedge clk); while (busy);
		st = predict_masker(f, b, pe);
		accepted++;
		if (want >= 0 && st != want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("status of request func %0d: want %0d, predicted %0d", f, want, st);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (expected_q.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [mpbm_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == mpbm_pkg::CFG_MASK_CHAR)
			mask_char_r = val;
		else
			mask_len_r = val[3:0];
	endtask

	function automatic logic [7:0] text_sym();
		return ($urandom_range(0, 99) < 85) ? 8'(8'h61 + $urandom_range(0, 3))
			: 8'($urandom_range(0, 255));
	endfunction

	always @(posedge clk) begin
		masked_out_t got, want;
		if (arst_n && result_valid) begin
			got = '{has_byte, out_byte, is_mask, found_any, status, last};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	stim_row_t directed[] = '{
		'{mpbm_pkg::F_TEXT, 8'h61, 1'b0, mpbm_pkg::ST_NOBUILD},
		'{F_NOP5, 8'h00, 1'b1, mpbm_pkg::ST_OK},
		'{F_NOP7, 8'hFF, 1'b0, mpbm_pkg::ST_OK},
		'{mpbm_pkg::F_PATTERN, 8'h68, 1'b0, mpbm_pkg::ST_OK},
		'{mpbm_pkg::F_PATTERN, 8'h65, 1'b0, mpbm_pkg::ST_OK},
		'{mpbm_pkg::F_PATTERN, 8'hFF, 1'b1, mpbm_pkg::ST_OK},
		'{mpbm_pkg::F_PATTERN, 8'h00, 1'b1, mpbm_pkg::ST_OK},
		'{mpbm_pkg::F_PATTERN, 8'h73, 1'b0, mpbm_pkg::ST_OK},
		'{mpbm_pkg::F_PATTERN, 8'h68, 1'b1, mpbm_pkg::ST_OK},
		'{mpbm_pkg::F_BUILD, 8'h00, 1'b0, mpbm_pkg::ST_OK},
		'{mpbm_pkg::F_TEXT, 8'h75, 1'b0, -1},
		'{mpbm_pkg::F_TEXT, 8'h73, 1'b0, -1},
		'{mpbm_pkg::F_TEXT, 8'h68, 1'b0, -1},
		'{mpbm_pkg::F_TEXT, 8'h65, 1'b0, -1},
		'{mpbm_pkg::F_TEXT, 8'hFF, 1'b0, -1},
		'{mpbm_pkg::F_TEXT, 8'h00, 1'b0, -1},
		'{mpbm_pkg::F_TEXT, 8'h68, 1'b0, -1},
		'{mpbm_pkg::F_TEXT, 8'h65, 1'b0, -1},
		'{mpbm_pkg::F_EOT, 8'h00, 1'b0, -1},
		'{mpbm_pkg::F_EOT, 8'h00, 1'b0, -1},
		'{mpbm_pkg::F_PATTERN, 8'h78, 1'b1, mpbm_pkg::ST_OK},
		'{mpbm_pkg::F_TEXT, 8'h78, 1'b0, mpbm_pkg::ST_NOBUILD},
		'{mpbm_pkg::F_CLEAR, 8'h00, 1'b0, mpbm_pkg::ST_OK},
		'{mpbm_pkg::F_TEXT, 8'h61, 1'b0, mpbm_pkg::ST_NOBUILD}
	};

	initial begin
		int unsigned session, plen, tlen, start_count;
		logic pe;
		trie_clear();
		mask_char_r = mpbm_pkg::MASK_CHAR_RST;
		mask_len_r = mpbm_pkg::MASK_LEN_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_request(directed[i].func, directed[i].data, directed[i].pend,
				directed[i].want_status);
		wait_drained();

		start_count = accepted;
		session = 0;
		while (accepted - start_count < RANDOM_ITEMS) begin
			case (session % 5)
				0: begin
					write_reg(mpbm_pkg::CFG_MASK_LEN, 8'd0);
					write_reg(mpbm_pkg::CFG_MASK_CHAR, 8'h00);
				end
				1: begin
					write_reg(mpbm_pkg::CFG_MASK_LEN, 8'd15);
					write_reg(mpbm_pkg::CFG_MASK_CHAR, 8'hFF);
				end
				default: begin
					write_reg(mpbm_pkg::CFG_MASK_LEN, 8'($urandom_range(0, 15)));
					write_reg(mpbm_pkg::CFG_MASK_CHAR, 8'($urandom_range(0, 255)));
				end
			endcase
			no_gaps = (session == 3);
			repeat ($urandom_range(1, 3)) begin
				plen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 18) : $urandom_range(1, 4);
				for (int j = 0; j < plen; j++) begin
					pe = (j == plen - 1) || ($urandom_range(0, 29) == 0);
					send_request(mpbm_pkg::F_PATTERN, text_sym(), pe);
				end
				if ($urandom_range(0, 9) == 0)
					send_request(mpbm_pkg::F_TEXT, text_sym(), 1'($urandom_range(0, 1)));
			end
			send_request(mpbm_pkg::F_BUILD, 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));
			tlen = $urandom_range(10, 30);
			repeat (tlen) begin
				if ($urandom_range(0, 24) == 0)
					send_request(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)), 1'b0);
				send_request(mpbm_pkg::F_TEXT, text_sym(), 1'($urandom_range(0, 1)));
			end
			send_request(mpbm_pkg::F_EOT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			wait_drained();
			session++;
		end
		no_gaps = 0;

		// fill the node table, then push one more pattern into the full table
		while (nodes_used < mpbm_pkg::NODE_COUNT)
			for (int j = 0; j < mpbm_pkg::MAX_PATTERN_LEN; j++)
				send_request(mpbm_pkg::F_PATTERN, 8'($urandom_range(0, 255)),
					j == mpbm_pkg::MAX_PATTERN_LEN - 1);
		for (int j = 0; j < 3; j++)
			send_request(mpbm_pkg::F_PATTERN, 8'($urandom_range(0, 255)), j == 2);

		start <= 1'b0;
		while (expected_q.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[files.f]
hdl/mpbm_pkg.sv
hdl/mpbm_ram.sv
hdl/multi_pattern_byte_masker_top.sv
tb/sv/multi_pattern_byte_masker_top_tb.sv
